// File: design/gte_rt_pkg.sv
// Shared types, register numbers and helper functions of the coprocessor register transfer block.
package gte_rt_pkg;

  // Transfer codes carried in the opcode field
  typedef enum logic [2:0] {
    OP_DATA_READ   = 3'd0,
    OP_CTRL_READ   = 3'd1,
    OP_DATA_WRITE  = 3'd2,
    OP_CTRL_WRITE  = 3'd3,
    OP_WORD_LOAD   = 3'd4,
    OP_WORD_STORE  = 3'd5
  } op_e;

  // Fault codes reported with a result
  typedef enum logic [1:0] {
    FLT_NONE  = 2'd0,
    FLT_LOAD  = 2'd1,
    FLT_STORE = 2'd2
  } fault_e;

  // Data register numbers with special behavior
  localparam logic [4:0] DR_VZ0  = 5'd1;
  localparam logic [4:0] DR_VZ1  = 5'd3;
  localparam logic [4:0] DR_VZ2  = 5'd5;
  localparam logic [4:0] DR_OTZ  = 5'd7;
  localparam logic [4:0] DR_IR0  = 5'd8;
  localparam logic [4:0] DR_IR1  = 5'd9;
  localparam logic [4:0] DR_IR2  = 5'd10;
  localparam logic [4:0] DR_IR3  = 5'd11;
  localparam logic [4:0] DR_SXY0 = 5'd12;
  localparam logic [4:0] DR_SXY1 = 5'd13;
  localparam logic [4:0] DR_SXY2 = 5'd14;
  localparam logic [4:0] DR_SXYP = 5'd15;
  localparam logic [4:0] DR_SZ0  = 5'd16;
  localparam logic [4:0] DR_SZ1  = 5'd17;
  localparam logic [4:0] DR_SZ2  = 5'd18;
  localparam logic [4:0] DR_SZ3  = 5'd19;
  localparam logic [4:0] DR_IRGB = 5'd28;
  localparam logic [4:0] DR_ORGB = 5'd29;
  localparam logic [4:0] DR_LZCS = 5'd30;
  localparam logic [4:0] DR_LZCR = 5'd31;

  // Control register numbers with special behavior
  localparam logic [4:0] CR_RT33 = 5'd4;
  localparam logic [4:0] CR_L33  = 5'd12;
  localparam logic [4:0] CR_LR33 = 5'd20;
  localparam logic [4:0] CR_H    = 5'd26;
  localparam logic [4:0] CR_DQA  = 5'd27;
  localparam logic [4:0] CR_ZSF3 = 5'd29;
  localparam logic [4:0] CR_ZSF4 = 5'd30;
  localparam logic [4:0] CR_FLAG = 5'd31;

  localparam logic [31:0] FLAG_KEEP_MASK  = 32'h7fff_f000;
  localparam logic [31:0] FLAG_ERROR_MASK = 32'h7f87_e000;
  localparam logic [31:0] FLAG_SUMMARY    = 32'h8000_0000;

  // Input item
  typedef struct packed {
    logic [2:0]         opcode;
    logic [4:0]         reg_index;
    logic [31:0]        write_value;
    logic [31:0]        base_address;
    logic signed [15:0] offset;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [31:0] read_data;
    logic        mem_write;
    logic [31:0] mem_address;
    logic [1:0]  fault;
  } out_item_t;

  // Request from the transfer control to the register file
  typedef struct packed {
    logic        data_rd;
    logic        ctrl_rd;
    logic        data_wr;
    logic        ctrl_wr;
    logic [4:0]  idx;
    logic [31:0] value;
  } rf_req_t;

  // Sign-extend the low half of a word
  function automatic logic [31:0] sext16(input logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  // IR value >> 7 clamped to 0..31, negative values give 0
  function automatic logic [4:0] colour_field(input logic [31:0] r);
    logic [4:0] res;
    if (r[15]) begin
      res = 5'd0;
    end else if (|r[14:12]) begin
      res = 5'h1f;
    end else begin
      res = r[11:7];
    end
    return res;
  endfunction

  // Number of leading bits equal to bit 31, 1..32
  function automatic logic [5:0] leading_bits(input logic [31:0] v);
    logic [31:0] t;
    logic [5:0]  n;
    t = v[31] ? ~v : v;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (t[i]) begin
        n = 6'(31 - i);
      end
    end
    return n;
  endfunction

endpackage

// File: design/gte_rt_regfile.sv
// Data and control register files with the read and write side effects of each register.
module gte_rt_regfile (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gte_rt_pkg::rf_req_t req_i,
  output logic [31:0]         rdata_o
);

  logic [31:0] data_q [32];
  logic [31:0] data_d [32];
  logic [31:0] ctrl_q [32];
  logic [31:0] ctrl_d [32];
  logic [31:0] data_rval;
  logic [31:0] ctrl_wval;

  // Data read value, including extension and packed colour
  always_comb begin
    case (req_i.idx) inside
      gte_rt_pkg::DR_VZ0, gte_rt_pkg::DR_VZ1, gte_rt_pkg::DR_VZ2,
      gte_rt_pkg::DR_IR0, gte_rt_pkg::DR_IR1, gte_rt_pkg::DR_IR2,
      gte_rt_pkg::DR_IR3: begin
        data_rval = gte_rt_pkg::sext16(data_q[req_i.idx]);
      end
      gte_rt_pkg::DR_OTZ, gte_rt_pkg::DR_SZ0, gte_rt_pkg::DR_SZ1,
      gte_rt_pkg::DR_SZ2, gte_rt_pkg::DR_SZ3: begin
        data_rval = {16'd0, data_q[req_i.idx][15:0]};
      end
      gte_rt_pkg::DR_SXYP: begin
        data_rval = data_q[gte_rt_pkg::DR_SXY2];
      end
      gte_rt_pkg::DR_IRGB, gte_rt_pkg::DR_ORGB: begin
        data_rval = {17'd0,
                     gte_rt_pkg::colour_field(data_q[gte_rt_pkg::DR_IR3]),
                     gte_rt_pkg::colour_field(data_q[gte_rt_pkg::DR_IR2]),
                     gte_rt_pkg::colour_field(data_q[gte_rt_pkg::DR_IR1])};
      end
      default: begin
        data_rval = data_q[req_i.idx];
      end
    endcase
  end

  // Control write value
  always_comb begin
    case (req_i.idx) inside
      gte_rt_pkg::CR_RT33, gte_rt_pkg::CR_L33, gte_rt_pkg::CR_LR33,
      gte_rt_pkg::CR_H, gte_rt_pkg::CR_DQA, gte_rt_pkg::CR_ZSF3,
      gte_rt_pkg::CR_ZSF4: begin
        ctrl_wval = gte_rt_pkg::sext16(req_i.value);
      end
      gte_rt_pkg::CR_FLAG: begin
        ctrl_wval = req_i.value & gte_rt_pkg::FLAG_KEEP_MASK;
        if (|(req_i.value & gte_rt_pkg::FLAG_ERROR_MASK)) begin
          ctrl_wval = ctrl_wval | gte_rt_pkg::FLAG_SUMMARY;
        end
      end
      default: begin
        ctrl_wval = req_i.value;
      end
    endcase
  end

  // Next state of the data registers
  always_comb begin
    data_d = data_q;
    if (req_i.data_rd) begin
      // a read leaves the returned value in the register
      data_d[req_i.idx] = data_rval;
    end else if (req_i.data_wr) begin
      case (req_i.idx)
        gte_rt_pkg::DR_SXYP: begin
          data_d[gte_rt_pkg::DR_SXY0] = data_q[gte_rt_pkg::DR_SXY1];
          data_d[gte_rt_pkg::DR_SXY1] = data_q[gte_rt_pkg::DR_SXY2];
          data_d[gte_rt_pkg::DR_SXY2] = req_i.value;
          data_d[gte_rt_pkg::DR_SXYP] = req_i.value;
        end
        gte_rt_pkg::DR_IRGB: begin
          data_d[gte_rt_pkg::DR_IR1] = {20'd0, req_i.value[4:0], 7'd0};
          data_d[gte_rt_pkg::DR_IR2] = {20'd0, req_i.value[9:5], 7'd0};
          data_d[gte_rt_pkg::DR_IR3] = {20'd0, req_i.value[14:10], 7'd0};
          data_d[gte_rt_pkg::DR_IRGB] = req_i.value;
        end
        gte_rt_pkg::DR_LZCS: begin
          data_d[gte_rt_pkg::DR_LZCR] = {26'd0, gte_rt_pkg::leading_bits(req_i.value)};
          data_d[gte_rt_pkg::DR_LZCS] = req_i.value;
        end
        gte_rt_pkg::DR_LZCR: begin
          // read-only
        end
        default: begin
          data_d[req_i.idx] = req_i.value;
        end
      endcase
    end
  end

  // Next state of the control registers
  always_comb begin
    ctrl_d = ctrl_q;
    if (req_i.ctrl_wr) begin
      ctrl_d[req_i.idx] = ctrl_wval;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) begin
        data_q[i] <= '0;
        ctrl_q[i] <= '0;
      end
    end else begin
      data_q <= data_d;
      ctrl_q <= ctrl_d;
    end
  end

  assign rdata_o = req_i.ctrl_rd ? ctrl_q[req_i.idx] : data_rval;

endmodule

// File: design/gte_register_transfer.sv
// Top level of the coprocessor register transfer block: input register, transfer control, result register.
// An item is held in the input register and is executed against the register files as
// it moves into the result register, which then presents its result, and one item is taken
// every cycle while the result side keeps up. The
// register files are updated at the same edge that captures the result, so each item
// sees all the writes of the items before it. Loads and stores compute base + offset
// and fault on a misaligned address without touching any register.
module gte_register_transfer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  gte_rt_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gte_rt_pkg::out_item_t out_item_o
);

  gte_rt_pkg::in_item_t  in_q;
  logic                  in_valid_q;
  gte_rt_pkg::out_item_t out_q;
  gte_rt_pkg::out_item_t out_d;
  logic                  out_valid_q;
  logic                  advance;
  logic                  take_in;
  logic [31:0]           addr;
  logic                  aligned;
  logic [31:0]           rdata;
  gte_rt_pkg::rf_req_t   req;

  // Handshake: the item in the input register moves on when the result slot frees up
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign take_in    = in_valid_i && !in_stall_o;

  assign addr    = in_q.base_address + {{16{in_q.offset[15]}}, in_q.offset};
  assign aligned = (addr[1:0] == 2'b00);

  // Decode the transfer into a register file request and a result
  always_comb begin
    req       = '0;
    req.idx   = in_q.reg_index;
    req.value = in_q.write_value;
    out_d     = '0;
    case (in_q.opcode)
      gte_rt_pkg::OP_DATA_READ: begin
        req.data_rd     = advance;
        out_d.read_data = rdata;
      end
      gte_rt_pkg::OP_CTRL_READ: begin
        req.ctrl_rd     = 1'b1;
        out_d.read_data = rdata;
      end
      gte_rt_pkg::OP_DATA_WRITE: begin
        req.data_wr = advance;
      end
      gte_rt_pkg::OP_CTRL_WRITE: begin
        req.ctrl_wr = advance;
      end
      gte_rt_pkg::OP_WORD_LOAD: begin
        out_d.mem_address = addr;
        if (aligned) begin
          req.data_wr = advance;
        end else begin
          out_d.fault = gte_rt_pkg::FLT_LOAD;
        end
      end
      gte_rt_pkg::OP_WORD_STORE: begin
        out_d.mem_address = addr;
        if (aligned) begin
          req.data_rd     = advance;
          out_d.read_data = rdata;
          out_d.mem_write = 1'b1;
        end else begin
          out_d.fault = gte_rt_pkg::FLT_STORE;
        end
      end
      default: begin
        // unused opcodes give an all-zero result
      end
    endcase
  end

  gte_rt_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (rdata)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_q <= in_item_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
